// ===== design/signed_radix_ascii_convert_core_defines.svh =====
// Assertion macros used by the core's datapath.
`ifndef SIGNED_RADIX_ASCII_CONVERT_CORE_DEFINES_SVH
`define SIGNED_RADIX_ASCII_CONVERT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SRAC_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srac assertion failed");
// next-cycle implication
`define SRAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srac assertion failed");
`else
`define SRAC_ASSERT(lbl, clk, rst_n, ante, cons)
`define SRAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/srac_pkg.sv =====
package srac_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RADIX_W         = 5;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [3:0] DIGIT_TEN  = 4'd10;

    typedef struct packed {
        logic load;
        logic step;
        logic emit_sign;
        logic emit_digit;
    } t_ctl_cmd;

    typedef struct packed {
        logic div_done;   // quotient of this division step ends at zero
        logic negative;
        logic one_left;   // one digit left in the stack
        logic out_free;   // output register can take a beat
    } t_dp_sts;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d >= DIGIT_TEN) begin
            c = CHAR_A + {4'd0, d - DIGIT_TEN};
        end else begin
            c = CHAR_ZERO + {4'd0, d};
        end
        return c;
    endfunction

endpackage

// ===== design/srac_if.sv =====
interface srac_in_if #(parameter int VALUE_WIDTH = srac_pkg::VALUE_WIDTH_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface srac_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface srac_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [srac_pkg::RADIX_W-1:0]   radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

// ===== design/srac_ctrl.sv =====
module srac_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output srac_pkg::t_ctl_cmd o_cmd,
    input  srac_pkg::t_dp_sts  i_sts
);
    import srac_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_DIGIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = i_sts.negative ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_sts.one_left) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== design/srac_datapath.sv =====
`include "signed_radix_ascii_convert_core_defines.svh"

module srac_datapath #(
    parameter int VALUE_WIDTH = srac_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_cfg_valid,
    input  logic [srac_pkg::RADIX_W-1:0]  i_cfg_radix,
    input  srac_pkg::t_ctl_cmd            i_cmd,
    output srac_pkg::t_dp_sts             o_sts,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [7:0]                    o_out_char,
    output logic                          o_out_last
);
    import srac_pkg::*;

    localparam int NBYTES = (VALUE_WIDTH + 7) / 8;
    localparam int MAG_W  = NBYTES * 8;
    localparam int BIW    = (NBYTES > 1) ? $clog2(NBYTES) : 1;
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

    logic [RADIX_W-1:0]          r_radix;
    logic [RADIX_W-1:0]          n_radix;
    logic                        r_neg;
    logic [NBYTES-1:0][7:0]      r_mag;
    logic [BIW-1:0]              r_idx;
    logic [BIW-1:0]              r_top;
    logic [3:0]                  r_rem;
    logic [3:0]                  r_stack [VALUE_WIDTH];
    logic [CNT_W-1:0]            r_count;
    logic                        r_out_valid;
    logic [7:0]                  r_out_char;
    logic                        r_out_last;

    logic [VALUE_WIDTH-1:0]      w_raw;
    logic                        w_neg;
    logic [VALUE_WIDTH-1:0]      w_mag;
    logic [NBYTES-1:0][7:0]      w_mag_bytes;
    logic [BIW-1:0]              w_load_top;
    logic [7:0]                  w_q;
    logic [3:0]                  w_rem;
    logic                        w_last_byte;
    logic [BIW-1:0]              w_next_top;
    logic                        w_out_free;

    // clamp radix writes into 2..16
    always_comb begin
        if (i_cfg_radix < RADIX_MIN) begin
            n_radix = RADIX_MIN;
        end else if (i_cfg_radix > RADIX_MAX) begin
            n_radix = RADIX_MAX;
        end else begin
            n_radix = i_cfg_radix;
        end
    end

    // magnitude and its highest nonzero byte
    always_comb begin
        w_raw       = i_value;
        w_neg       = w_raw[VALUE_WIDTH-1];
        w_mag       = w_neg ? VALUE_WIDTH'(~w_raw + 1'b1) : w_raw;
        w_mag_bytes = MAG_W'(w_mag);
        w_load_top  = '0;
        for (int i = 0; i < NBYTES; i++) begin
            if (w_mag_bytes[i] != 8'd0) begin
                w_load_top = BIW'(i);
            end
        end
    end

    // long division of one byte by the radix, one bit per sub-step
    always_comb begin
        logic [7:0] byte_in;
        logic [4:0] t;
        logic [3:0] rem;
        byte_in = r_mag[r_idx];
        rem     = r_rem;
        w_q     = '0;
        for (int b = 7; b >= 0; b--) begin
            t = {rem, byte_in[b]};
            if (t >= r_radix) begin
                w_q[b] = 1'b1;
                rem    = 4'(t - r_radix);
            end else begin
                rem    = t[3:0];
            end
        end
        w_rem = rem;
    end

    // quotient loses at most four bits, so the top byte drops by one at most
    always_comb begin
        w_last_byte = (r_idx == '0);
        if ((r_idx == r_top) && (w_q == 8'd0) && (r_top != '0)) begin
            w_next_top = r_top - 1'b1;
        end else begin
            w_next_top = r_top;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.div_done = w_last_byte && (r_top == '0) && (w_q == 8'd0);
        o_sts.negative = r_neg;
        o_sts.one_left = (r_count == CNT_W'(1));
        o_sts.out_free = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= RADIX_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_radix <= n_radix;
            end
            if (i_cmd.load) begin
                r_count <= '0;
            end else if (i_cmd.step && w_last_byte) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.emit_digit) begin
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.emit_sign || i_cmd.emit_digit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= w_neg;
            r_mag <= w_mag_bytes;
            r_top <= w_load_top;
            r_idx <= w_load_top;
            r_rem <= 4'd0;
        end else if (i_cmd.step) begin
            r_mag[r_idx] <= w_q;
            r_top        <= w_next_top;
            if (w_last_byte) begin
                // digit complete: push remainder, restart on the quotient
                r_idx      <= w_next_top;
                r_rem      <= 4'd0;
                r_stack[0] <= w_rem;
                for (int i = 1; i < VALUE_WIDTH; i++) begin
                    r_stack[i] <= r_stack[i-1];
                end
            end else begin
                r_idx <= r_idx - 1'b1;
                r_rem <= w_rem;
            end
        end else if (i_cmd.emit_digit) begin
            for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
            r_stack[VALUE_WIDTH-1] <= 4'd0;
        end

        if (i_cmd.emit_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= digit_char(r_stack[0]);
            r_out_last <= (r_count == CNT_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

    `SRAC_ASSERT(a_radix_range, i_clk, i_rst_n, 1'b1, (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX))
    `SRAC_ASSERT(a_pop_nonempty, i_clk, i_rst_n, i_cmd.emit_digit, r_count != '0)
    `SRAC_ASSERT_NEXT(a_load_clears, i_clk, i_rst_n, i_cmd.load, (r_count == '0) && (r_rem == 4'd0))
    `SRAC_ASSERT(a_emit_free, i_clk, i_rst_n, i_cmd.emit_sign || i_cmd.emit_digit, w_out_free)
    `SRAC_ASSERT(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(VALUE_WIDTH))

endmodule

// ===== design/signed_radix_ascii_convert_core.sv =====
// Flow: load in IDLE, D division steps, optional sign, then the digits; D = division steps.
// D = sum over digits of the magnitude's significant byte count (one byte of
// long division per cycle, ceil(VALUE_WIDTH/8) at most per digit).
// A new value is accepted only after the last digit of the previous one is emitted.
// Reset: synchronous active low; radix returns to 10, channels empty, ready for input.
module signed_radix_ascii_convert_core #(
    parameter int VALUE_WIDTH = srac_pkg::VALUE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srac_in_if.sink       i_in_if,
    srac_out_if.source    o_out_if,
    srac_cfg_if.sink      i_cfg_if
);
    import srac_pkg::*;

    t_ctl_cmd w_cmd;
    t_dp_sts  w_sts;
    logic     w_in_ready;

    srac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_if.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    srac_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_in_if.value),
        .i_cfg_valid (i_cfg_if.valid),
        .i_cfg_radix (i_cfg_if.radix),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_out_if.ready),
        .o_out_valid (o_out_if.valid),
        .o_out_char  (o_out_if.character),
        .o_out_last  (o_out_if.last)
    );

    assign i_in_if.ready  = w_in_ready;
    assign i_cfg_if.ready = 1'b1;

endmodule

// ===== verif/srac_radix_text_checker.sv =====
module srac_radix_text_checker #(
    parameter int VW = srac_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [VW-1:0]                i_in_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [7:0]                   i_out_character,
    input  logic                         i_out_last,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [srac_pkg::RADIX_W-1:0] i_cfg_radix,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import srac_pkg::*;

    typedef struct {
        logic [7:0]    character;
        logic          last;
        logic [VW-1:0] source;
    } text_beat_t;

    text_beat_t         expected_text[$];
    logic [RADIX_W-1:0] radix_q;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        radix_q      = RADIX_RESET;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic logic [7:0] numeral(input logic [RADIX_W-1:0] d);
        if (d >= RADIX_W'(DIGIT_TEN)) begin
            return CHAR_A + 8'(d - RADIX_W'(DIGIT_TEN));
        end
        return CHAR_ZERO + 8'(d);
    endfunction

    // sign first, then digits most significant first; last flag on the final one
    task automatic predict_run(input logic [VW-1:0] raw);
        logic [VW-1:0] mag;
        logic [7:0]    digits [0:VW];
        logic          negative;
        int            n;
        negative = raw[VW-1];
        mag      = negative ? (~raw + 1'b1) : raw;
        n        = 0;
        do begin
            digits[n] = numeral(RADIX_W'(mag % VW'(radix_q)));
            mag       = mag / VW'(radix_q);
            n++;
        end while (mag != '0);
        if (negative) begin
            expected_text.push_back('{character: CHAR_MINUS, last: 1'b0, source: raw});
        end
        for (int k = n - 1; k >= 0; k--) begin
            expected_text.push_back('{character: digits[k], last: (k == 0), source: raw});
        end
    endtask

    always @(posedge i_clk) begin
        text_beat_t want;
        if (!i_rst_n) begin
            radix_q = RADIX_RESET;
            expected_text.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_radix < RADIX_MIN) begin
                    radix_q = RADIX_MIN;
                end else if (i_cfg_radix > RADIX_MAX) begin
                    radix_q = RADIX_MAX;
                end else begin
                    radix_q = i_cfg_radix;
                end
            end
            // output first: a beat can never belong to a value taken at this same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat char 0x%0h last %0b",
                                              i_out_character, i_out_last));
                end else begin
                    want = expected_text.pop_front();
                    if (i_out_character !== want.character) begin
                        report_mismatch($sformatf("value 0x%0h char got 0x%0h exp 0x%0h",
                                                  want.source, i_out_character,
                                                  want.character));
                    end
                    if (i_out_last !== want.last) begin
                        report_mismatch($sformatf("value 0x%0h last got %0b exp %0b",
                                                  want.source, i_out_last, want.last));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_run(i_in_value);
            end
        end
        o_pending = expected_text.size();
    end

endmodule

// ===== verif/tb_signed_radix_ascii_convert_core.sv =====
module tb_signed_radix_ascii_convert_core;
    timeunit 1ns;
    timeprecision 1ps;

    import srac_pkg::*;

    localparam int VW            = VALUE_WIDTH_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 200;
    localparam int RAND_PER_SET  = 16;

    localparam logic [VW-1:0] MOST_NEG = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] MOST_POS = {1'b0, {(VW-1){1'b1}}};

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   text_pending;
    int   cycles = 0;
    int   send_idle_pct;
    int   recv_idle_pct;

    always #1ns i_clk = ~i_clk;

    srac_in_if #(.VALUE_WIDTH(VW)) in_ch ();
    srac_out_if                    out_ch ();
    srac_cfg_if                    cfg_ch ();

    signed_radix_ascii_convert_core #(.VALUE_WIDTH(VW)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_if  (in_ch),
        .o_out_if (out_ch),
        .i_cfg_if (cfg_ch)
    );

    srac_radix_text_checker #(.VW(VW)) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_ch.valid),
        .i_in_ready      (in_ch.ready),
        .i_in_value      (in_ch.value),
        .i_out_valid     (out_ch.valid),
        .i_out_ready     (out_ch.ready),
        .i_out_character (out_ch.character),
        .i_out_last      (out_ch.last),
        .i_cfg_valid     (cfg_ch.valid),
        .i_cfg_ready     (cfg_ch.ready),
        .i_cfg_radix     (cfg_ch.radix),
        .o_fail_count    (fail_count),
        .o_pending       (text_pending)
    );

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // valid stays high after the beat; callers that stop sending drop it in the same step
    task automatic send_value(input logic [VW-1:0] v);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (text_pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        in_ch.valid <= 1'b0;
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.radix <= r;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [VW-1:0] random_value();
        logic [VW-1:0] v;
        case ($urandom_range(0, 4))
            0: v = VW'($urandom);
            1: v = VW'($urandom_range(0, 40));
            2: v = MOST_POS - VW'($urandom_range(0, 3));
            3: v = MOST_NEG + VW'($urandom_range(0, 3));
            default: v = VW'($urandom) >> $urandom_range(0, VW - 1);
        endcase
        if ($urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    task automatic random_phase();
        repeat (3) begin
            write_radix(RADIX_W'($urandom_range(0, 31)));
            repeat (RAND_PER_SET) send_value(random_value());
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.value  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.radix <= '0;
        send_idle_pct = 7;
        recv_idle_pct = 68;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset radix is ten
        send_value('0);
        send_value(VW'(1));
        send_value('1);
        send_value(VW'(9));
        send_value(VW'(10));
        send_value(-VW'(10));
        send_value(VW'(15));
        send_value(VW'(16));
        send_value(MOST_POS);
        send_value(MOST_NEG);

        write_radix(RADIX_MIN);
        send_value(MOST_NEG);
        send_value(MOST_POS);
        write_radix(RADIX_MAX);
        send_value(VW'(255));
        send_value(MOST_NEG);
        // clamped writes
        write_radix('0);
        send_value(VW'(1));
        send_value(-VW'(2));
        write_radix('1);
        send_value(VW'(32'h00AB_CDEF));
        send_value(-VW'(32'h00AB_CDEF));
        write_radix(RADIX_MAX + 1'b1);
        send_value('0);
        send_value(VW'(15));
        write_radix(RADIX_MIN - 1'b1);
        send_value('0);
        send_value('1);
        write_radix(RADIX_W'(8));
        send_value(MOST_NEG);
        send_value(VW'(7));

        random_phase();
        send_idle_pct = 68;
        recv_idle_pct = 7;
        random_phase();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase();

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
